[rtl/mbr_pkg.sv]
// Package: shared types, codes and defaults for the MRU-bit replacement block.
`default_nettype none
package mbr_pkg;

    localparam int unsigned DEF_SETS = 2048;
    localparam int unsigned DEF_WAYS = 16;

    localparam int unsigned SET_W = 11;
    localparam int unsigned WAY_W = 4;

    // action codes
    localparam logic ACT_QUERY  = 1'b0;
    localparam logic ACT_UPDATE = 1'b1;

    typedef struct packed {
        logic             action;
        logic [SET_W-1:0] set_index;
        logic [WAY_W-1:0] way;
        logic             hit;
        logic             is_write;
    } t_req_item;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } t_state;

endpackage
`default_nettype wire

[rtl/mbr_if.sv]
// Interfaces: request and response channels of the MRU-bit replacement block.
`default_nettype none
interface mbr_req_if
    import mbr_pkg::*;
();
    logic      valid;
    logic      ready;
    t_req_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mbr_rsp_if
    import mbr_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [WAY_W-1:0] victim_way;

    modport source (output valid, output victim_way, input ready);
    modport sink   (input valid, input victim_way, output ready);
endinterface
`default_nettype wire

[rtl/mru_bit_replacement.sv]
// Top level: MRU-bit (bit pseudo-LRU) cache replacement state and victim selection.
// ----------------------------------------------------------------------------
// Usage
//   i_req : one item per handshake. action = query returns the lowest way of
//           set_index whose used bit is clear (way 0 if none). action = update
//           marks the way used on a miss or a non-write hit; a set that
//           becomes all ones is cleared. Updates produce no response.
//   o_rsp : one victim_way item per query, in request order.
// Timing
//   A query's response is registered in the response slot after the read stage.
//   One item per cycle unless a held response stalls: the set word is read
//   from the RAM on the accepting edge, written back as the read stage advances;
//   a back-to-back item to the same set takes the word from a forwarding register.
// Reset
//   After i_rst_n is released the RAM is swept to zero, one set per cycle,
//   from set 0 to SETS-1; i_req.ready stays low during the sweep.
// Stall
//   A held response keeps its value. A further query waits in the read stage,
//   and the request side is held off until the response slot frees; the
//   input keeps flowing while the slot frees in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module mru_bit_replacement
    import mbr_pkg::*;
#(
    parameter int unsigned SETS = DEF_SETS,
    parameter int unsigned WAYS = DEF_WAYS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mbr_req_if.sink    i_req,
    mbr_rsp_if.source  o_rsp
);

    localparam int unsigned AW = (SETS > 1) ? $clog2(SETS) : 1;
    localparam logic [AW-1:0] LAST_SET = AW'(SETS - 1);

    t_state r_state, n_state;
    logic [AW-1:0] r_clr_addr, n_clr_addr;

    // read stage
    logic      r_s1_valid;
    t_req_item r_s1_item;
    logic            r_fwd_hit;
    logic [WAYS-1:0] r_fwd_bits;

    // response slot
    logic             r_out_valid;
    logic [WAY_W-1:0] r_out_way;

    logic            in_acc;
    logic            s1_go;
    logic            out_free;
    logic            s1_query;
    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   s1_addr;
    logic [31:0]     rd_idx32;
    logic [31:0]     s1_idx32;
    logic [WAYS-1:0] ram_rdata;
    logic [WAYS-1:0] s1_bits;
    logic            calc_we;
    logic [WAYS-1:0] calc_wbits;
    logic [WAY_W-1:0] calc_victim;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [WAYS-1:0] ram_wdata;

    // clear sweep controller
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        unique case (r_state)
            ST_CLEAR: begin
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == LAST_SET) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                n_clr_addr = '0;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // handshakes
    assign s1_query = (r_s1_item.action == ACT_QUERY);
    assign out_free = !r_out_valid || o_rsp.ready;
    assign s1_go    = r_s1_valid && (!s1_query || out_free);
    assign i_req.ready = (r_state == ST_RUN) && (!r_s1_valid || s1_go);
    assign in_acc   = i_req.valid && i_req.ready;

    assign rd_idx32 = 32'(i_req.data.set_index);
    assign rd_addr  = rd_idx32[AW-1:0];
    assign s1_idx32 = 32'(r_s1_item.set_index);
    assign s1_addr  = s1_idx32[AW-1:0];

    // RAM write port: sweep during clear, write-back otherwise
    assign ram_we    = (r_state == ST_CLEAR) || (calc_we && s1_go);
    assign ram_waddr = (r_state == ST_CLEAR) ? r_clr_addr : s1_addr;
    assign ram_wdata = (r_state == ST_CLEAR) ? '0 : calc_wbits;

    mbr_ram #(
        .DEPTH (SETS),
        .WIDTH (WAYS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_acc),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    // the RAM read on the same edge as a write-back to that set sees old data
    assign s1_bits = r_fwd_hit ? r_fwd_bits : ram_rdata;

    mbr_calc #(
        .SETS (SETS),
        .WAYS (WAYS)
    ) u_calc (
        .i_valid  (r_s1_valid),
        .i_item   (r_s1_item),
        .i_bits   (s1_bits),
        .o_we     (calc_we),
        .o_wbits  (calc_wbits),
        .o_victim (calc_victim)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
                r_fwd_hit  <= ram_we && (ram_waddr == rd_addr);
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_item  <= i_req.data;
            r_fwd_bits <= ram_wdata;
        end
    end

    // response slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && s1_query) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && s1_query) begin
            r_out_way <= calc_victim;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.victim_way = r_out_way;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !in_acc)
        else $error("request accepted during RAM clear");

    a_stalled_query_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && s1_query && r_out_valid && !o_rsp.ready)
            |=> (r_s1_valid && $stable(r_s1_item)))
        else $error("stalled query lost from read stage");

    a_rsp_from_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s1_valid && s1_query))
        else $error("response without a query");

    a_no_writeback_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !r_s1_valid)
        else $error("pipeline active during RAM clear");

endmodule
`default_nettype wire

[rtl/mbr_ram.sv]
// Simple dual-port RAM holding one used-bit word per set, registered read.
`default_nettype none
module mbr_ram
    import mbr_pkg::*;
#(
    parameter int unsigned DEPTH = DEF_SETS,
    parameter int unsigned WIDTH = DEF_WAYS,
    parameter int unsigned AW    = SET_W
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // read-before-write on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

[rtl/mbr_calc.sv]
// Per-set update and victim pick on one used-bit word.
`default_nettype none
module mbr_calc
    import mbr_pkg::*;
#(
    parameter int unsigned SETS = DEF_SETS,
    parameter int unsigned WAYS = DEF_WAYS
) (
    input  wire logic            i_valid,
    input  wire t_req_item       i_item,
    input  wire logic [WAYS-1:0] i_bits,
    output logic                 o_we,
    output logic      [WAYS-1:0] o_wbits,
    output logic      [WAY_W-1:0] o_victim
);

    localparam logic [WAYS-1:0] FULL = '1;

    logic            set_ok;
    logic            way_ok;
    logic [WAYS-1:0] marked;
    logic [31:0]     pick;

    assign set_ok = 32'(i_item.set_index) < SETS;
    assign way_ok = 32'(i_item.way) < WAYS;

    always_comb begin
        marked = i_bits;
        if (!i_item.hit || !i_item.is_write) begin
            marked = i_bits | (WAYS'(1) << i_item.way);
        end
        // a full set wraps back to empty
        o_wbits = (marked == FULL) ? '0 : marked;
    end

    assign o_we = i_valid && (i_item.action == ACT_UPDATE) && set_ok && way_ok;

    // lowest clear way, way 0 when all set or the set index is out of range
    always_comb begin
        pick = '0;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (!i_bits[i]) begin
                pick = 32'(i);
            end
        end
        if (!set_ok) begin
            pick = '0;
        end
    end

    assign o_victim = pick[WAY_W-1:0];

endmodule
`default_nettype wire

[verif/mru_bit_replacement_test.sv]
// Testbench: self-checking run of the MRU-bit replacement block, directed then random.
`timescale 1ns / 100ps
module mru_bit_replacement_test;
    import mbr_pkg::*;

    localparam int N_DIRECTED = 17;
    localparam int N_RANDOM   = 600;
    localparam int POOL_SIZE  = 8;

    // One row of the directed table; victim is typed in only where fixed is set.
    typedef struct packed {
        logic             action;
        logic [SET_W-1:0] set_index;
        logic [WAY_W-1:0] way;
        logic             hit;
        logic             is_write;
        logic             fixed;
        logic [WAY_W-1:0] victim;
    } t_directed_row;

    // One pending request item, with an optional hand-written victim.
    typedef struct {
        t_req_item        item;
        bit               fixed;
        logic [WAY_W-1:0] fixed_victim;
    } t_req_row;

    // Opening checks: empty sets after reset, ignored fields of a query, fills,
    // write hits that leave the bit alone, non-write hits and write misses that
    // mark it, both ends of the set range, and an untouched neighbor set.
    localparam t_directed_row DIRECTED_ROWS [N_DIRECTED] = '{
        '{ACT_QUERY,  11'd0,    4'd0,  1'b0, 1'b0, 1'b1, 4'd0},
        '{ACT_QUERY,  11'd2047, 4'd15, 1'b1, 1'b1, 1'b1, 4'd0},
        '{ACT_UPDATE, 11'd0,    4'd0,  1'b0, 1'b0, 1'b0, 4'd0},
        '{ACT_QUERY,  11'd0,    4'd0,  1'b0, 1'b0, 1'b1, 4'd1},
        '{ACT_UPDATE, 11'd0,    4'd1,  1'b1, 1'b1, 1'b0, 4'd0},
        '{ACT_QUERY,  11'd0,    4'd9,  1'b1, 1'b0, 1'b1, 4'd1},
        '{ACT_UPDATE, 11'd0,    4'd1,  1'b1, 1'b0, 1'b0, 4'd0},
        '{ACT_QUERY,  11'd0,    4'd0,  1'b0, 1'b1, 1'b1, 4'd2},
        '{ACT_UPDATE, 11'd0,    4'd2,  1'b0, 1'b1, 1'b0, 4'd0},
        '{ACT_QUERY,  11'd0,    4'd0,  1'b0, 1'b0, 1'b1, 4'd3},
        '{ACT_UPDATE, 11'd2047, 4'd15, 1'b0, 1'b0, 1'b0, 4'd0},
        '{ACT_QUERY,  11'd2047, 4'd0,  1'b0, 1'b0, 1'b1, 4'd0},
        '{ACT_UPDATE, 11'd2047, 4'd0,  1'b1, 1'b0, 1'b0, 4'd0},
        '{ACT_QUERY,  11'd2047, 4'd0,  1'b0, 1'b0, 1'b1, 4'd1},
        '{ACT_QUERY,  11'd1,    4'd0,  1'b0, 1'b0, 1'b1, 4'd0},
        '{ACT_UPDATE, 11'd1024, 4'd8,  1'b0, 1'b0, 1'b0, 4'd0},
        '{ACT_QUERY,  11'd1024, 4'd0,  1'b0, 1'b0, 1'b1, 4'd0}
    };

    logic i_clk;
    logic i_rst_n;

    mbr_req_if req_ch ();
    mbr_rsp_if rsp_ch ();

    mru_bit_replacement dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    // Shadow of the per-set used bits and the victims still owed by the block
    logic [DEF_WAYS-1:0] used_bits [DEF_SETS];
    logic [WAY_W-1:0]    victim_q [$];
    t_req_row            req_q [$];

    int accepted_items;
    int total_items;
    int queries_sent;
    int victims_checked;
    int set_clears;
    int error_count;
    bit req_fired;
    logic [WAY_W-1:0] want_victim;

    always #10 i_clk = ~i_clk;

    // Lowest way whose bit is clear; way 0 when the whole set is marked.
    function automatic logic [WAY_W-1:0] lowest_clear_way(logic [DEF_WAYS-1:0] bits);
        logic [WAY_W-1:0] w;
        w = '0;
        for (int i = DEF_WAYS - 1; i >= 0; i--) begin
            if (!bits[i]) w = WAY_W'(i);
        end
        return w;
    endfunction

    function automatic t_req_item make_item(logic act, logic [SET_W-1:0] s,
                                            logic [WAY_W-1:0] w, logic h, logic wr);
        t_req_item it;
        it.action    = act;
        it.set_index = s;
        it.way       = w;
        it.hit       = h;
        it.is_write  = wr;
        return it;
    endfunction

    function automatic t_req_item random_item();
        return make_item(1'($urandom_range(0, 1)), SET_W'($urandom_range(0, DEF_SETS - 1)),
                         WAY_W'($urandom_range(0, DEF_WAYS - 1)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endfunction

    // An access that marks its way: any miss, or a hit that is not a write.
    function automatic t_req_item marking_access(logic [SET_W-1:0] s, logic [WAY_W-1:0] w);
        case ($urandom_range(0, 2))
            0: return make_item(ACT_UPDATE, s, w, 1'b0, 1'b0);
            1: return make_item(ACT_UPDATE, s, w, 1'b0, 1'b1);
            default: return make_item(ACT_UPDATE, s, w, 1'b1, 1'b0);
        endcase
    endfunction

    function automatic void push_random(t_req_item it);
        t_req_row r;
        r.item         = it;
        r.fixed        = 1'b0;
        r.fixed_victim = '0;
        req_q.push_back(r);
    endfunction

    // Idle phases follow progress through the accepted items.
    function automatic int sender_idle_pct();
        if (accepted_items < total_items / 3) return 22;
        else if (accepted_items < 2 * total_items / 3) return 51;
        return 0;
    endfunction

    function automatic int receiver_stall_pct();
        if (accepted_items < total_items / 3) return 51;
        else if (accepted_items < 2 * total_items / 3) return 22;
        return 0;
    endfunction

    // Advance the shadow state for an accepted item; queries queue their victim.
    function automatic void track_request(t_req_row r);
        logic [DEF_WAYS-1:0] bits;
        if (r.item.action == ACT_QUERY) begin
            victim_q.push_back(r.fixed ? r.fixed_victim
                                       : lowest_clear_way(used_bits[r.item.set_index]));
            queries_sent++;
        end else begin
            bits = used_bits[r.item.set_index];
            if (!r.item.hit || !r.item.is_write) bits[r.item.way] = 1'b1;
            if (&bits) begin
                bits = '0;
                set_clears++;
            end
            used_bits[r.item.set_index] = bits;
        end
    endfunction

    // Request driver: valid holds until the item is taken, then the next item
    // may follow at once or after a random gap.
    always @(posedge i_clk) begin
        req_fired = 1'b0;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                track_request(req_q.pop_front());
                accepted_items++;
                req_fired = 1'b1;
            end
            if (req_ch.valid && !req_fired) begin
                // stalled: keep the item on the bus
            end else if (req_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
                req_ch.valid <= 1'b1;
                req_ch.data  <= req_q[0].item;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Response side: random back-pressure, then compare against the oldest victim.
    always @(posedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct());
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (victim_q.size() == 0) begin
                $error("victim_way: no response expected, actual %0d", rsp_ch.victim_way);
                error_count++;
            end else begin
                want_victim = victim_q.pop_front();
                victims_checked++;
                if (rsp_ch.victim_way !== want_victim) begin
                    $error("victim_way mismatch: expected %0d, actual %0d",
                           want_victim, rsp_ch.victim_way);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #4_000_000;
        $display("FAIL mru_bit_replacement");
        $finish;
    end

    initial begin
        logic [SET_W-1:0] set_pool [POOL_SIZE];
        int               way_order [DEF_WAYS];
        t_req_row         row;
        logic [SET_W-1:0] s;
        int               j;
        int               tmp;
        int               len;

        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.data     = '0;
        rsp_ch.ready    = 1'b0;
        accepted_items  = 0;
        queries_sent    = 0;
        victims_checked = 0;
        set_clears      = 0;
        error_count     = 0;
        for (int i = 0; i < DEF_SETS; i++) used_bits[i] = '0;

        for (int i = 0; i < N_DIRECTED; i++) begin
            row.item = make_item(DIRECTED_ROWS[i].action, DIRECTED_ROWS[i].set_index,
                                 DIRECTED_ROWS[i].way, DIRECTED_ROWS[i].hit,
                                 DIRECTED_ROWS[i].is_write);
            row.fixed        = DIRECTED_ROWS[i].fixed;
            row.fixed_victim = DIRECTED_ROWS[i].victim;
            req_q.push_back(row);
        end

        // A few hot sets so that bits pile up, sets fill and clear, and
        // back-to-back items hit the same set.
        set_pool[0] = '0;
        set_pool[1] = '1;
        set_pool[2] = SET_W'(1);
        set_pool[3] = SET_W'(1024);
        for (int i = 4; i < POOL_SIZE; i++) set_pool[i] = SET_W'($urandom_range(0, DEF_SETS - 1));

        while (req_q.size() < N_DIRECTED + N_RANDOM) begin
            s = set_pool[$urandom_range(0, POOL_SIZE - 1)];
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    // fill pass: marking accesses in shuffled way order, mostly to
                    // the point where the set turns all ones and clears
                    for (int i = 0; i < DEF_WAYS; i++) way_order[i] = i;
                    for (int i = DEF_WAYS - 1; i > 0; i--) begin
                        j = $urandom_range(0, i);
                        tmp = way_order[i];
                        way_order[i] = way_order[j];
                        way_order[j] = tmp;
                    end
                    len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, DEF_WAYS) : DEF_WAYS;
                    for (int i = 0; i < len; i++) begin
                        if ($urandom_range(0, 7) == 0)
                            push_random(make_item(ACT_UPDATE, s,
                                                  WAY_W'($urandom_range(0, DEF_WAYS - 1)),
                                                  1'b1, 1'b1));
                        push_random(marking_access(s, WAY_W'(way_order[i])));
                        if ($urandom_range(0, 1) == 0) begin
                            row.item = random_item();
                            row.item.action    = ACT_QUERY;
                            row.item.set_index = s;
                            push_random(row.item);
                        end
                    end
                end
                5, 6, 7: begin
                    // mixed traffic on one hot set
                    len = $urandom_range(4, 12);
                    for (int i = 0; i < len; i++) begin
                        row.item = random_item();
                        row.item.set_index = s;
                        push_random(row.item);
                    end
                end
                default: push_random(random_item());
            endcase
        end
        total_items = req_q.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The block sweeps its store before taking items; the driver just waits.
        while (req_q.size() != 0) @(posedge i_clk);
        while (victim_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Covered %0d items (%0d queries sent): %0d victims checked, %0d sets cleared.",
                 accepted_items, queries_sent, victims_checked, set_clears);
        if (error_count == 0 && victim_q.size() == 0) begin
            $display("PASS mru_bit_replacement");
        end else begin
            $display("FAIL mru_bit_replacement");
        end
        $finish;
    end

endmodule
